FILE: rtl/fbtc_pkg.sv
// ----------------------------------------------------------------------------
// fbtc_pkg: shared types and helpers for the five-bit text codec
// Beat formats, result bundle and the group-to-character mapping.
// ----------------------------------------------------------------------------
package fbtc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned GroupW  = 5;
  localparam int unsigned AccW    = 12;   // widest working accumulator
  localparam int unsigned CountW  = 3;    // residue bit count
  localparam int unsigned MaxRes  = 3;    // results per input beat
  localparam int unsigned ResCntW = 2;

  localparam logic [GroupW-1:0] GroupMask = 5'h1F;
  localparam logic [ByteW-1:0]  UpperBase = 8'h40;
  localparam logic [ByteW-1:0]  LowerBase = 8'h20;
  localparam logic [GroupW-1:0] LowTop    = 5'h0F;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } fbtc_item_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             valid;
    logic             last;
  } fbtc_res_t;

  typedef struct packed {
    fbtc_res_t [MaxRes-1:0] res;
    logic [ResCntW-1:0]     count;
  } fbtc_bundle_t;

  // Map a 5-bit group to its printable character.
  function automatic logic [ByteW-1:0] to_char(input logic [GroupW-1:0] grp);
    logic [GroupW-1:0] v;
    v = grp & GroupMask;
    if (v <= LowTop) begin
      to_char = UpperBase | {3'b000, v};
    end else begin
      to_char = LowerBase | {3'b000, v};
    end
  endfunction

  // Mask with the low n bits set.
  function automatic logic [AccW-1:0] low_mask(input logic [3:0] n);
    low_mask = (AccW'(1) << n) - AccW'(1);
  endfunction

endpackage

FILE: rtl/fbtc_in_stage.sv
// ----------------------------------------------------------------------------
// fbtc_in_stage: input holding register
// Captures one input beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
module fbtc_in_stage import fbtc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  fbtc_item_t item_in,
  input  logic       take,
  output logic       held,
  output fbtc_item_t item_out
);

  logic       full;
  fbtc_item_t item;

  assign item_ready = !full || take;
  assign held       = full;
  assign item_out   = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (item_valid && item_ready) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  // Payload: load on every accepted beat.
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item <= item_in;
    end
  end

endmodule

FILE: rtl/fbtc_core.sv
// ----------------------------------------------------------------------------
// fbtc_core: bit regrouping core
// Holds mode and residue; turns one held beat into up to three results.
// ----------------------------------------------------------------------------
module fbtc_core import fbtc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_mode,
  input  fbtc_item_t   item,
  input  logic         fire,
  output fbtc_bundle_t bundle
);

  logic              mode;
  logic [ByteW-1:0]  residue;
  logic [CountW-1:0] count;
  logic [ByteW-1:0]  residue_next;
  logic [CountW-1:0] count_next;

  // Encode path
  logic [CountW-1:0] r_enc;
  logic [AccW-1:0]   acc_e;
  logic [3:0]        nb_e;
  logic              two_e;
  logic [GroupW-1:0] g1_e;
  logic [GroupW-1:0] g2_e;
  logic [3:0]        rem_e;
  logic [AccW-1:0]   left_e;
  logic [GroupW-1:0] flush_e;
  logic              pad_e;
  logic [ResCntW-1:0] n_e;

  // Decode path
  logic [AccW-1:0]   acc_d;
  logic [3:0]        nb_d;
  logic              full_d;
  logic [ByteW-1:0]  byte_d;
  logic [3:0]        rem_d;
  logic [AccW-1:0]   left_d;

  always_comb begin
    r_enc   = (count > 3'd4) ? 3'd4 : count;
    acc_e   = ((AccW'(residue) & low_mask({1'b0, r_enc})) << 8) | AccW'(item.data);
    nb_e    = {1'b0, r_enc} + 4'd8;
    two_e   = (nb_e >= 4'd10);
    g1_e    = GroupW'(acc_e >> (nb_e - 4'd5));
    g2_e    = GroupW'(acc_e >> (nb_e - 4'd10));
    rem_e   = two_e ? (nb_e - 4'd10) : (nb_e - 4'd5);
    left_e  = acc_e & low_mask(rem_e);
    flush_e = GroupW'(left_e << (4'd5 - rem_e));
    pad_e   = item.last && (rem_e != 4'd0);
    n_e     = (two_e ? 2'd2 : 2'd1) + (pad_e ? 2'd1 : 2'd0);

    acc_d   = ((AccW'(residue) & low_mask({1'b0, count})) << 5)
              | AccW'(item.data[GroupW-1:0]);
    nb_d    = {1'b0, count} + 4'd5;
    full_d  = (nb_d >= 4'd8);
    byte_d  = ByteW'(acc_d >> (nb_d - 4'd8));
    rem_d   = full_d ? (nb_d - 4'd8) : nb_d;
    left_d  = acc_d & low_mask(rem_d);
  end

  always_comb begin
    bundle = '0;
    if (mode == MODE_ENCODE) begin
      bundle.count        = n_e;
      bundle.res[0].data  = to_char(g1_e);
      bundle.res[0].valid = 1'b1;
      bundle.res[0].last  = item.last && (n_e == 2'd1);
      bundle.res[1].data  = two_e ? to_char(g2_e) : to_char(flush_e);
      bundle.res[1].valid = 1'b1;
      bundle.res[1].last  = item.last && (n_e == 2'd2);
      bundle.res[2].data  = to_char(flush_e);
      bundle.res[2].valid = 1'b1;
      bundle.res[2].last  = item.last;
    end else begin
      if (full_d) begin
        bundle.count        = 2'd1;
        bundle.res[0].data  = byte_d;
        bundle.res[0].valid = 1'b1;
        bundle.res[0].last  = item.last;
      end else if (item.last) begin
        // Bare end marker: nothing completed on the final character.
        bundle.count        = 2'd1;
        bundle.res[0].last  = 1'b1;
      end
    end
  end

  always_comb begin
    if (item.last) begin
      residue_next = '0;
      count_next   = '0;
    end else if (mode == MODE_ENCODE) begin
      residue_next = ByteW'(left_e);
      count_next   = CountW'(rem_e);
    end else begin
      residue_next = ByteW'(left_d);
      count_next   = CountW'(rem_d);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_ENCODE;
      residue <= '0;
      count   <= '0;
    end else if (cfg_we) begin
      // Mode change drops any partial stream.
      mode    <= cfg_mode;
      residue <= '0;
      count   <= '0;
    end else if (fire) begin
      residue <= residue_next;
      count   <= count_next;
    end
  end

endmodule

FILE: rtl/fbtc_out_queue.sv
// ----------------------------------------------------------------------------
// fbtc_out_queue: result register
// Holds one beat's results and hands them out one per cycle while result_ready is high.
// ----------------------------------------------------------------------------
module fbtc_out_queue import fbtc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  fbtc_bundle_t bundle,
  input  logic         load,
  output logic         space,
  output logic         result_valid,
  input  logic         result_ready,
  output fbtc_res_t    head
);

  fbtc_res_t [MaxRes-1:0] res;
  logic [ResCntW-1:0]     count;
  logic                   pop;

  assign result_valid = (count != '0);
  assign pop          = result_valid && result_ready;
  assign space        = (count == '0) || ((count == 2'd1) && pop);
  assign head         = res[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= bundle.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  // Advance the queue by one entry on each pop.
  always_ff @(posedge clk) begin
    if (load) begin
      res <= bundle.res;
    end else if (pop) begin
      res[0] <= res[1];
      res[1] <= res[2];
    end
  end

endmodule

FILE: rtl/five_bit_text_codec.sv
// ----------------------------------------------------------------------------
// five_bit_text_codec: 5-bit group binary/text stream codec
// Encodes bytes into printable 5-bit characters or decodes them back.
// ----------------------------------------------------------------------------
// Usage:
//   Config channel (cfg_valid/cfg_ready, data on mode) selects encode (0) or
//   decode (1); cfg_ready is always high. A write also drops any partial
//   stream, so write only while the block is idle.
//   Input channel (item_valid/item_ready) carries data_byte and last_byte.
//   A beat with last_byte set flushes the residue and ends the stream.
//   Result channel (result_valid/result_ready) carries out_byte, out_valid
//   and out_last. In encode mode one input beat gives one to three results,
//   in decode mode zero or one; a bare end marker (out_valid low) closes a
//   decode stream whose last character completes no byte.
// Timing: an accepted beat passes the input register, then the result
//   register, before its first result reaches the result port. Throughput
//   is set by the result port, one result per cycle while result_ready is
//   high.
// Reset clears mode to encode, empties both registers and the residue.
// A stalled receiver holds the head result; the input register still takes
//   one more beat, then item_ready drops until the result register drains.
// ----------------------------------------------------------------------------
module five_bit_text_codec import fbtc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       mode,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last
);

  fbtc_item_t   item_in;
  fbtc_item_t   item_held;
  fbtc_bundle_t bundle;
  fbtc_res_t    head;
  logic         held;
  logic         space;
  logic         fire;

  assign cfg_ready    = 1'b1;
  assign item_in.data = data_byte;
  assign item_in.last = last_byte;

  // Move the held beat into the result register once it has room.
  assign fire = held && space;

  fbtc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item_in    (item_in),
    .take       (fire),
    .held       (held),
    .item_out   (item_held)
  );

  fbtc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_mode (mode),
    .item     (item_held),
    .fire     (fire),
    .bundle   (bundle)
  );

  fbtc_out_queue u_out_queue (
    .clk          (clk),
    .rst          (rst),
    .bundle       (bundle),
    .load         (fire),
    .space        (space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .head         (head)
  );

  assign out_byte  = head.data;
  assign out_valid = head.valid;
  assign out_last  = head.last;

endmodule

FILE: rtl/fbtc_checker.sv
// ----------------------------------------------------------------------------
// fbtc_checker: port-level checks for the five-bit text codec
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module fbtc_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] out_byte,
  input logic       out_valid,
  input logic       out_last
);

  // No result right after reset.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat present right after reset");

  // A stalled result beat stays.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      $stable(out_byte) && $stable(out_valid) && $stable(out_last))
    else $error("result payload changed while stalled");

  // A bare end marker always closes a stream and carries a zero byte.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !out_valid |-> out_last && (out_byte == 8'h00))
    else $error("bare marker without end of stream or with data");

endmodule

bind five_bit_text_codec fbtc_checker u_fbtc_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .out_byte     (out_byte),
  .out_valid    (out_valid),
  .out_last     (out_last)
);

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the five-bit text codec
// Streams of bytes and characters go through the block in both modes. A
// software copy of the codec predicts every result beat, and a scoreboard
// checks each beat in order; in the random test both sides idle and stall.
// ----------------------------------------------------------------------------
module tb;
  import fbtc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;  // generous cap on the whole run
  localparam int DRAIN_CYCLES = 8;      // two-stage pipe plus margin
  localparam int HOLD_CYCLES = 120;     // long receiver stall for the fill test

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_mode = MODE_ENCODE;
  logic       item_valid = 1'b0;
  logic       item_ready;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  // Knobs shared by the stimulus and the receiver, in percent per cycle.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // The test bumps the request count; the receiver process owns the countdown.
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  int error_count = 0;
  int cycle_count = 0;

  // Codec state as the bench sees it: mode, pending bits and their number.
  logic       codec_mode;
  logic [7:0] pend_bits;
  logic [2:0] pend_count;
  fbtc_res_t  expected_q[$];

  five_bit_text_codec dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .mode         (cfg_mode),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte),
    .out_valid    (out_valid),
    .out_last     (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Prediction helpers
  // ------------------------------------------------------------------------

  // Keep the low n bits of a working word.
  function automatic logic [11:0] keep_low(input int n);
    keep_low = ~(12'hFFF << n);
  endfunction

  // Upper half of the group range lands on 0x30..0x3F, lower half on 0x40..0x4F.
  function automatic logic [7:0] group_char(input logic [4:0] g);
    group_char = g[4] ? {4'h3, g[3:0]} : {4'h4, g[3:0]};
  endfunction

  // Work out the result beats of one accepted input beat and queue them.
  task automatic predict_beat(input logic [7:0] d, input logic fin);
    fbtc_res_t   outs [3];
    logic [11:0] acc;
    int          n;
    int          nb;
    int          r;
    n = 0;
    r = pend_count;
    if (codec_mode == MODE_ENCODE) begin
      if (r > 4) r = 4;
      acc = ((12'(pend_bits) & keep_low(r)) << 8) | 12'(d);
      nb = r + 8;
      // Peel off whole groups, oldest bits first.
      while (nb >= 5) begin
        nb -= 5;
        outs[n] = '{group_char(5'(acc >> nb)), 1'b1, 1'b0};
        n++;
      end
      acc &= keep_low(nb);
      // Pad the tail group with zeros on the right.
      if (fin && nb > 0) begin
        outs[n] = '{group_char(5'(acc << (5 - nb))), 1'b1, 1'b0};
        n++;
      end
    end else begin
      // Only the low five bits of a character carry data.
      acc = ((12'(pend_bits) & keep_low(r)) << 5) | 12'(d[4:0]);
      nb = r + 5;
      if (nb >= 8) begin
        nb -= 8;
        outs[n] = '{8'(acc >> nb), 1'b1, 1'b0};
        n++;
      end
      acc &= keep_low(nb);
      // A stream that ends without a full byte still gets a bare end marker.
      if (fin && n == 0) begin
        outs[n] = '{8'h00, 1'b0, 1'b0};
        n++;
      end
    end
    if (fin) begin
      outs[n-1].last = 1'b1;
      pend_bits = '0;
      pend_count = '0;
    end else begin
      pend_bits = 8'(acc);
      pend_count = 3'(nb);
    end
    for (int k = 0; k < n; k++) expected_q.push_back(outs[k]);
  endtask

  // ------------------------------------------------------------------------
  // Monitor: track config and input beats, score every result beat
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : score
    fbtc_res_t want;
    if (rst) begin
      codec_mode = MODE_ENCODE;
      pend_bits = '0;
      pend_count = '0;
    end else begin
      // A mode write also drops whatever partial stream is pending.
      if (cfg_valid && cfg_ready) begin
        codec_mode = cfg_mode;
        pend_bits = '0;
        pend_count = '0;
      end
      if (item_valid && item_ready) predict_beat(data_byte, last_byte);
      if (result_valid && result_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result beat: out_byte=%02h out_valid=%0b out_last=%0b",
                 out_byte, out_valid, out_last);
          error_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_byte);
            error_count++;
          end
          if (out_valid !== want.valid) begin
            $error("out_valid: expected %0b, got %0b", want.valid, out_valid);
            error_count++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_last);
            error_count++;
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // ------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus tasks: all enter and return just after a falling edge
  // ------------------------------------------------------------------------

  // Offer one input beat, idling first at the sender's rate, and hold it
  // until accepted. Valid stays high on return so the next beat can follow.
  task automatic send_item(input logic [7:0] d, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    data_byte <= d;
    last_byte <= fin;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Send a whole stream; close it with last_byte only when asked.
  task automatic send_stream(input logic [7:0] bytes[$], input logic close);
    for (int k = 0; k < bytes.size(); k++) begin
      send_item(bytes[k], close && (k == bytes.size() - 1));
    end
  endtask

  // Drop valid, wait for every expected beat, then let the pipe empty out
  // in case the final beats produced no result.
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write the mode register once the block is idle.
  task automatic set_mode(input logic m);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_mode <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly random bytes, with the all-zero and all-one patterns favored.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: pick_byte = 8'h00;
      1: pick_byte = 8'hFF;
      default: pick_byte = 8'($urandom_range(255));
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Encode: one-byte streams of both extremes, a two-byte stream that ends
  // with three characters out of one beat, and a five-byte stream that walks
  // the residue through every count. Finish with an open stream that
  // the next mode write must drop.
  task automatic test_encode_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_mode(MODE_ENCODE);
    send_stream('{8'hFF}, 1'b1);
    send_stream('{8'h00}, 1'b1);
    send_stream('{8'h80, 8'h01}, 1'b1);
    send_stream('{8'hA5, 8'h5A, 8'hFF, 8'h00, 8'hC3}, 1'b1);
    send_stream('{8'hA5, 8'h3C}, 1'b0);
  endtask

  // Decode: a lone character (bare end marker), a stream ending on a full
  // byte, a stream whose last character completes nothing after an earlier
  // byte, and an eight-character stream that ends with no leftover bits.
  // High bits of the characters are set to prove they are ignored.
  task automatic test_decode_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_mode(MODE_DECODE);
    send_stream('{8'hFF}, 1'b1);
    send_stream('{8'h1F, 8'hE0}, 1'b1);
    send_stream('{8'h00, 8'hFF, 8'hAA}, 1'b1);
    send_stream('{8'h1F, 8'h00, 8'hFF, 8'hE0, 8'h15, 8'h0A, 8'h1F, 8'h3F}, 1'b1);
  endtask

  // Random streams in both modes under each idling profile. A phase may end
  // mid-stream; the mode write that starts the next one drops the tail.
  task automatic test_random_streams();
    int idle_pct [4];
    int stall_pct [4];
    int sent;
    int len;
    idle_pct = '{0, 65, 0, 30};
    stall_pct = '{0, 0, 65, 30};
    for (int p = 0; p < 4; p++) begin
      for (int m = 0; m < 2; m++) begin
        send_idle_pct = idle_pct[p];
        recv_stall_pct = stall_pct[p];
        set_mode(m ? MODE_DECODE : MODE_ENCODE);
        sent = 0;
        while (sent < 48) begin
          len = $urandom_range(1, 12);
          for (int k = 0; k < len && sent < 48; k++) begin
            send_item(pick_byte(), k == len - 1);
            sent++;
          end
        end
      end
    end
  endtask

  // Hold the receiver off for a long stretch while the sender keeps pushing,
  // so both internal registers fill and item_ready drops.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_mode(MODE_ENCODE);
    hold_requests++;
    for (int k = 0; k < 24; k++) begin
      send_item(pick_byte(), (k % 6) == 5);
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_encode_directed();
    test_decode_directed();
    test_random_streams();
    test_backpressure();
    wait_drained();

    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
